[rtl/ihf_pkg.sv]
// ============================================================================
// ihf_pkg - shared types and constants of the IPv4 receive header filter
// Holds the request records of both channels, the per-packet record that the
// front end hands to the back end, the verdict codes and the register indexes.
// ============================================================================
package ihf_pkg;

    // Packet geometry
    localparam int MAX_PACKET_BYTES = 2047;
    localparam int HEADER_BYTES     = 20;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int PAYLOAD_W        = 11;

    // Header byte offsets
    localparam logic [POS_W-1:0] PROTO_POS   = POS_W'(9);
    localparam logic [POS_W-1:0] CSUM_LO_POS = POS_W'(11);
    localparam logic [POS_W-1:0] SRC_FIRST   = POS_W'(12);
    localparam logic [POS_W-1:0] SRC_LAST    = POS_W'(15);
    localparam logic [POS_W-1:0] DST_FIRST   = POS_W'(16);
    localparam logic [POS_W-1:0] DST_LAST    = POS_W'(19);
    localparam logic [POS_W-1:0] HDR_LEN     = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_MAX     = POS_W'(MAX_PACKET_BYTES);

    // Checksum and multicast constants
    localparam int SUM_W = 20;
    localparam logic [7:0] MCAST_MASK  = 8'hF0;
    localparam logic [7:0] MCAST_VALUE = 8'hE0;

    // Queue between front and back end
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WANTED_PROTOCOL = 1'd1;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        VERDICT_ACCEPTED    = 3'd0,
        VERDICT_TOO_SHORT   = 3'd1,
        VERDICT_BAD_CSUM    = 3'd2,
        VERDICT_WRONG_DEST  = 3'd3,
        VERDICT_WRONG_PROTO = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        verdict_t               verdict;
        logic [31:0]            source_address;
        logic [PAYLOAD_W-1:0]   payload_length;
    } out_item_t;

    // Everything the back end needs to judge one packet
    typedef struct packed {
        logic [POS_W-1:0] byte_count;
        logic [SUM_W-1:0] word_sum;
        logic [15:0]      received_checksum;
        logic [7:0]       protocol;
        logic [31:0]      source;
        logic [31:0]      destination;
    } hdr_rec_t;

endpackage

[rtl/ipv4_receive_header_filter.sv]
// ============================================================================
// ipv4_receive_header_filter - IPv4 receive header check and filter
// Judges each received IPv4 packet by header checksum, destination and
// protocol, and reports the source address and payload length.
// ============================================================================
//
//  channel   handshake         request                    when taken
//  -------   ---------------   ------------------------   ----------------------
//  input     push / full       item: byte + last mark     push && !full
//  result    empty / pop       result: verdict, source,   pop && !empty
//                              payload length
//  config    cfg_write         cfg_index, cfg_data        cfg_write (no wait)
//
//  One byte is taken every cycle while full is low; per-byte work is one
//  header-word add and a field capture in the front end. A packet's result
//  shows on the result ports once its record has crossed the two-entry queue
//  and the back end has registered the verdict.
//  full rises only when two packet records wait behind an untaken result.
//  Reset clears the byte counter, header state, queue, output valid flag and
//  both configuration registers; no clearing pass is needed.
//
module ipv4_receive_header_filter (
    input  logic                                clk,
    input  logic                                rst_n,
    // byte input, queue style
    input  logic                                push,
    output logic                                full,
    input  ihf_pkg::in_item_t                   item,
    // result output, queue style
    output logic                                empty,
    input  logic                                pop,
    output ihf_pkg::out_item_t                  result,
    // configuration writes
    input  logic                                cfg_write,
    input  logic [ihf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ihf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic               accept;
    logic               rec_push;
    ihf_pkg::hdr_rec_t  front_rec;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    ihf_pkg::hdr_rec_t  q_head;

    // Hold input whenever the queue has no room for a packet record
    assign full   = q_full;
    assign accept = push && !q_full;

    // Front end: count bytes, sum header words, capture fields
    ihf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .rec_push (rec_push),
        .rec      (front_rec)
    );

    // Decouple the front end from the verdict stage
    ihf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (rec_push),
        .push_rec (front_rec),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (q_head)
    );

    // Back end: judge the packet, hold the result until popped
    ihf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rec_valid (q_valid),
        .rec       (q_head),
        .rec_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

[rtl/ihf_front.sv]
// ============================================================================
// ihf_front - byte front end of the IPv4 receive header filter
// Counts packet bytes, sums header words and captures the header fields; on
// the last byte emits one packet record and clears for the next packet.
// ============================================================================
module ihf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  ihf_pkg::in_item_t  item,
    output logic               rec_push,
    output ihf_pkg::hdr_rec_t  rec
);

    logic [ihf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [ihf_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [7:0]                hi_reg, hi_next;
    logic [15:0]               csum_reg, csum_next;
    logic [7:0]                proto_reg, proto_next;
    logic [31:0]               src_reg, src_next;
    logic [31:0]               dst_reg, dst_next;

    logic [ihf_pkg::POS_W-1:0] cap_pos;
    logic [ihf_pkg::SUM_W-1:0] cap_sum;
    logic [7:0]                cap_hi;
    logic [15:0]               cap_csum;
    logic [7:0]                cap_proto;
    logic [31:0]               cap_src;
    logic [31:0]               cap_dst;
    logic [15:0]               word;

    assign word = {hi_reg, item.packet_byte};

    // Fold the current byte into the header state
    always_comb
    begin
        cap_pos   = pos_reg;
        cap_sum   = sum_reg;
        cap_hi    = hi_reg;
        cap_csum  = csum_reg;
        cap_proto = proto_reg;
        cap_src   = src_reg;
        cap_dst   = dst_reg;
        if (pos_reg < ihf_pkg::HDR_LEN)
        begin
            if (!pos_reg[0])
            begin
                cap_hi = item.packet_byte;
            end
            else if (pos_reg == ihf_pkg::CSUM_LO_POS)
            begin
                cap_csum = word;
            end
            else
            begin
                cap_sum = sum_reg + ihf_pkg::SUM_W'(word);
            end
            if (pos_reg == ihf_pkg::PROTO_POS)
            begin
                cap_proto = item.packet_byte;
            end
            if (pos_reg >= ihf_pkg::SRC_FIRST && pos_reg <= ihf_pkg::SRC_LAST)
            begin
                cap_src = {src_reg[23:0], item.packet_byte};
            end
            if (pos_reg >= ihf_pkg::DST_FIRST && pos_reg <= ihf_pkg::DST_LAST)
            begin
                cap_dst = {dst_reg[23:0], item.packet_byte};
            end
        end
        // Saturate the count at its top value
        if (pos_reg != ihf_pkg::POS_MAX)
        begin
            cap_pos = pos_reg + 1'b1;
        end
    end

    // Advance on each byte, clear after the last one
    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        hi_next    = hi_reg;
        csum_next  = csum_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        if (accept)
        begin
            if (item.last_byte)
            begin
                pos_next   = '0;
                sum_next   = '0;
                hi_next    = '0;
                csum_next  = '0;
                proto_next = '0;
                src_next   = '0;
                dst_next   = '0;
            end
            else
            begin
                pos_next   = cap_pos;
                sum_next   = cap_sum;
                hi_next    = cap_hi;
                csum_next  = cap_csum;
                proto_next = cap_proto;
                src_next   = cap_src;
                dst_next   = cap_dst;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            hi_reg    <= '0;
            csum_reg  <= '0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            hi_reg    <= hi_next;
            csum_reg  <= csum_next;
            proto_reg <= proto_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
        end
    end

    assign rec_push              = accept && item.last_byte;
    assign rec.byte_count        = cap_pos;
    assign rec.word_sum          = cap_sum;
    assign rec.received_checksum = cap_csum;
    assign rec.protocol          = cap_proto;
    assign rec.source            = cap_src;
    assign rec.destination       = cap_dst;

endmodule

[rtl/ihf_queue.sv]
// ============================================================================
// ihf_queue - packet record queue between front and back end
// A short first-in first-out queue of packet records.
// ============================================================================
module ihf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ihf_pkg::hdr_rec_t  push_rec,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output ihf_pkg::hdr_rec_t  head
);

    ihf_pkg::hdr_rec_t           slot_reg [ihf_pkg::QUEUE_DEPTH];
    logic [ihf_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [ihf_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [ihf_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                        do_push;
    logic                        do_pop;

    assign full    = (count_reg == ihf_pkg::QCNT_W'(ihf_pkg::QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign head    = slot_reg[rd_ptr_reg];

    function automatic logic [ihf_pkg::QPTR_W-1:0] wrap_inc(
        input logic [ihf_pkg::QPTR_W-1:0] ptr
    );
        if (ptr == ihf_pkg::QPTR_W'(ihf_pkg::QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return ptr + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = do_push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

[rtl/ihf_back.sv]
// ============================================================================
// ihf_back - verdict back end of the IPv4 receive header filter
// Holds the configuration registers, judges one packet record per cycle while the
// output register is free or drained, and keeps each result there until taken.
// ============================================================================
module ihf_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [ihf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ihf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                rec_valid,
    input  ihf_pkg::hdr_rec_t                   rec,
    output logic                                rec_pop,
    output logic                                empty,
    input  logic                                pop,
    output ihf_pkg::out_item_t                  result
);

    logic [31:0]          own_address_reg;
    logic [7:0]           wanted_protocol_reg;
    logic                 out_valid_reg, out_valid_next;
    ihf_pkg::out_item_t   out_reg, out_next;

    logic [16:0]          fold1;
    logic [16:0]          fold2;
    logic                 csum_ok;
    logic                 dest_ok;
    logic                 too_short;
    ihf_pkg::verdict_t    verdict;

    // One's-complement fold of the header sum, done twice
    assign fold1 = 17'(rec.word_sum[15:0]) + 17'(rec.word_sum[ihf_pkg::SUM_W-1:16]);
    assign fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
    assign csum_ok = (~fold2[15:0]) == rec.received_checksum;
    assign dest_ok = (rec.destination == own_address_reg) ||
                     ((rec.destination[31:24] & ihf_pkg::MCAST_MASK) == ihf_pkg::MCAST_VALUE);
    assign too_short = rec.byte_count < ihf_pkg::HDR_LEN;

    always_comb
    begin
        priority if (too_short)
        begin
            verdict = ihf_pkg::VERDICT_TOO_SHORT;
        end
        else if (!csum_ok)
        begin
            verdict = ihf_pkg::VERDICT_BAD_CSUM;
        end
        else if (!dest_ok)
        begin
            verdict = ihf_pkg::VERDICT_WRONG_DEST;
        end
        else if (rec.protocol != wanted_protocol_reg)
        begin
            verdict = ihf_pkg::VERDICT_WRONG_PROTO;
        end
        else
        begin
            verdict = ihf_pkg::VERDICT_ACCEPTED;
        end
    end

    // Take a record whenever the output register is free or being drained
    assign rec_pop = rec_valid && (!out_valid_reg || pop);
    assign empty   = !out_valid_reg;
    assign result  = out_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end
        if (rec_pop)
        begin
            out_valid_next         = 1'b1;
            out_next.verdict       = verdict;
            if (too_short)
            begin
                out_next.source_address = '0;
                out_next.payload_length = '0;
            end
            else
            begin
                out_next.source_address = rec.source;
                out_next.payload_length =
                    ihf_pkg::PAYLOAD_W'(rec.byte_count - ihf_pkg::HDR_LEN);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg     <= '0;
            wanted_protocol_reg <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    ihf_pkg::REG_OWN_ADDRESS:
                    begin
                        own_address_reg <= cfg_data[31:0];
                    end
                    ihf_pkg::REG_WANTED_PROTOCOL:
                    begin
                        wanted_protocol_reg <= cfg_data[7:0];
                    end
                    default:
                    begin
                        own_address_reg <= own_address_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

[rtl/ihf_checker.sv]
// ============================================================================
// ihf_checker - port-level checks of the IPv4 receive header filter
// Tracks packets in flight from the port handshakes and checks that results
// and back pressure agree with them.
// ============================================================================
module ihf_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic                                full,
    input  ihf_pkg::in_item_t                   item,
    input  logic                                empty,
    input  logic                                pop,
    input  ihf_pkg::out_item_t                  result
);

    logic [2:0] pending_reg, pending_next;
    logic       pkt_in;
    logic       pkt_out;

    assign pkt_in  = push && !full && item.last_byte;
    assign pkt_out = pop && !empty;

    always_comb
    begin
        pending_next = pending_reg + 3'(pkt_in) - 3'(pkt_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // No result without a packet ended before it
    assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == 3'd0) |-> empty)
        else $error("result shown with no packet pending");

    // At most queue depth plus the output register in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'(ihf_pkg::QUEUE_DEPTH + 1))
        else $error("more packets in flight than storage");

    // Back pressure only when the queue really holds records
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (pending_reg >= 3'(ihf_pkg::QUEUE_DEPTH)))
        else $error("full without enough pending packets");

    // A finished packet met by an empty output crosses the queue and shows a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_in && empty) |=> ##1 !empty)
        else $error("result did not appear after last byte");

    // A too-short packet carries no source and no length
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.verdict == ihf_pkg::VERDICT_TOO_SHORT) |->
            (result.source_address == '0 && result.payload_length == '0))
        else $error("too-short result carries fields");

endmodule

bind ipv4_receive_header_filter ihf_checker u_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb - self-checking bench for the IPv4 receive header filter
// Feeds byte streams of received packets through the push/full side, checks
// every verdict request popped from the empty/pop side against a cycle-free
// prediction of the filter, and varies both registers between phases.
// ============================================================================
module tb;

    // Header layout as the predictor sees it
    localparam int HDR_BYTES    = 20;
    localparam int COUNT_TOP    = 2047;
    localparam int PROTO_AT     = 9;
    localparam int CSUM_LOW_AT  = 11;
    localparam int SRC_AT       = 12;
    localparam int DST_AT       = 16;

    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_BYTES = 300;
    localparam int DRAIN_CYCLES = 8;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             push;
    logic                             full;
    ihf_pkg::in_item_t                item;
    logic                             empty;
    logic                             pop = 1'b0;
    ihf_pkg::out_item_t               result;
    logic                             cfg_write;
    logic [ihf_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [ihf_pkg::CFG_DATA_W-1:0]   cfg_data;

    ipv4_receive_header_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Register copies as last written
    logic [31:0]        own_addr_reg;
    logic [7:0]         proto_reg;

    // Per-packet header tracking
    logic [10:0]        pkt_count;
    logic [19:0]        hdr_sum;
    logic [7:0]         hi_byte;
    logic [15:0]        csum_seen;
    logic [7:0]         proto_seen;
    logic [31:0]        src_seen;
    logic [31:0]        dst_seen;

    // Verdicts still owed by the filter, oldest first
    ihf_pkg::out_item_t pending_verdicts[$];

    // Bytes of the packet being built for sending
    logic [7:0]         frame[$];

    int                 errors;
    bit                 idle_on;
    int                 bytes_fed;
    int                 holds_asked;
    int                 holds_served;
    int                 hold_left;
    int                 stall_left;

    // ------------------------------------------------------------------
    // Header tracking
    // ------------------------------------------------------------------
    task automatic clear_packet();
        pkt_count  = '0;
        hdr_sum    = '0;
        hi_byte    = '0;
        csum_seen  = '0;
        proto_seen = '0;
        src_seen   = '0;
        dst_seen   = '0;
    endtask

    // Advance the header state by one accepted byte; on the last byte, judge
    // the packet and queue the verdict request it must produce.
    task automatic follow_byte(input logic [7:0] b, input logic last);
        int                 p;
        logic [15:0]        w;
        logic [16:0]        s;
        logic [15:0]        folded;
        bit                 dest_ok;
        ihf_pkg::out_item_t r;
        p = int'(pkt_count);
        if (p < HDR_BYTES)
        begin
            // Even offsets open a header word, odd offsets close it
            if (p % 2 == 0)
                hi_byte = b;
            else
            begin
                w = {hi_byte, b};
                if (p == CSUM_LOW_AT)
                    csum_seen = w;
                else
                    hdr_sum = hdr_sum + {4'd0, w};
            end
            if (p == PROTO_AT)
                proto_seen = b;
            if (p >= SRC_AT && p < SRC_AT + 4)
                src_seen = {src_seen[23:0], b};
            if (p >= DST_AT && p < DST_AT + 4)
                dst_seen = {dst_seen[23:0], b};
        end
        // Count saturates; bytes past the header only count
        if (p < COUNT_TOP)
            pkt_count = pkt_count + 11'd1;
        if (last)
        begin
            if (int'(pkt_count) < HDR_BYTES)
                r = '{verdict: ihf_pkg::VERDICT_TOO_SHORT, source_address: 32'd0,
                      payload_length: 11'd0};
            else
            begin
                // Fold the 20-bit sum twice, then compare its complement
                s = {1'b0, hdr_sum[15:0]} + {13'd0, hdr_sum[19:16]};
                s = {1'b0, s[15:0]} + {16'd0, s[16]};
                folded = ~s[15:0];
                dest_ok = (dst_seen == own_addr_reg) || (dst_seen[31:28] == 4'hE);
                if (folded != csum_seen)
                    r.verdict = ihf_pkg::VERDICT_BAD_CSUM;
                else if (!dest_ok)
                    r.verdict = ihf_pkg::VERDICT_WRONG_DEST;
                else if (proto_seen != proto_reg)
                    r.verdict = ihf_pkg::VERDICT_WRONG_PROTO;
                else
                    r.verdict = ihf_pkg::VERDICT_ACCEPTED;
                r.source_address = src_seen;
                r.payload_length = pkt_count - 11'(HDR_BYTES);
            end
            pending_verdicts.push_back(r);
            clear_packet();
        end
    endtask

    // ------------------------------------------------------------------
    // Sending side
    // ------------------------------------------------------------------
    // Offer one byte request and hold it until the filter takes it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        push <= 1'b1;
        item <= '{packet_byte: b, last_byte: last};
        do
            @(posedge clk);
        while (full);
        follow_byte(b, last);
        bytes_fed++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_byte(frame[i], i == frame.size() - 1);
    endtask

    // Build a 20-byte header with a correct or a spoiled checksum, append
    // random payload, and send it as one packet.
    task automatic send_packet(input logic [31:0] dst, input logic [7:0] proto,
                               input bit csum_good, input int payload_n);
        logic [7:0]  h[HDR_BYTES];
        int unsigned acc;
        logic [15:0] ck;
        for (int i = 0; i < HDR_BYTES; i++)
            h[i] = 8'($urandom);
        h[PROTO_AT] = proto;
        for (int i = 0; i < 4; i++)
            h[DST_AT + i] = dst[31 - 8 * i -: 8];
        acc = 0;
        for (int i = 0; i < HDR_BYTES; i += 2)
            if (i != CSUM_LOW_AT - 1)
                acc += {h[i], h[i + 1]};
        while (acc > 32'hFFFF)
            acc = (acc & 32'hFFFF) + (acc >> 16);
        ck = ~acc[15:0];
        if (!csum_good)
            ck = ck ^ 16'($urandom_range(1, 16'hFFFF));
        h[CSUM_LOW_AT - 1] = ck[15:8];
        h[CSUM_LOW_AT]     = ck[7:0];
        frame.delete();
        for (int i = 0; i < HDR_BYTES; i++)
            frame.push_back(h[i]);
        repeat (payload_n) frame.push_back(8'($urandom));
        send_frame();
    endtask

    // Random bytes with the last mark on the final one
    task automatic send_junk(input int n);
        frame.delete();
        repeat (n) frame.push_back(8'($urandom));
        send_frame();
    endtask

    function automatic logic [31:0] pick_dest();
        int k;
        k = $urandom_range(0, 5);
        if (k <= 1)
            return own_addr_reg;
        else if (k == 2)
            return {4'hE, 28'($urandom)};
        else if (k == 3)
            return ($urandom_range(0, 1) != 0) ? {8'hDF, 24'($urandom)}
                                               : {8'hF0, 24'($urandom)};
        else
            return $urandom;
    endfunction

    function automatic logic [7:0] pick_proto();
        return ($urandom_range(0, 3) != 0) ? proto_reg : 8'($urandom);
    endfunction

    // Wait until every owed verdict is in, then let the pipeline go quiet
    task automatic settle();
        push <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both registers while the filter is idle
    task automatic configure(input logic [31:0] addr, input logic [7:0] proto);
        settle();
        cfg_write <= 1'b1;
        cfg_index <= ihf_pkg::REG_OWN_ADDRESS;
        cfg_data  <= addr;
        @(posedge clk);
        cfg_index <= ihf_pkg::REG_WANTED_PROTOCOL;
        cfg_data  <= {24'd0, proto};
        @(posedge clk);
        cfg_write <= 1'b0;
        own_addr_reg = addr;
        proto_reg    = proto;
    endtask

    // ------------------------------------------------------------------
    // Receiving side: pop with random stalls, long hold-offs on request,
    // and check each popped verdict request against the oldest owed one.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        ihf_pkg::out_item_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result: verdict %0d source %h length %0d",
                             $time, result.verdict, result.source_address,
                             result.payload_length);
                    errors++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (result.verdict !== want.verdict)
                    begin
                        $display("%0t: verdict expected %0d actual %0d",
                                 $time, want.verdict, result.verdict);
                        errors++;
                    end
                    if (result.source_address !== want.source_address)
                    begin
                        $display("%0t: source_address expected %h actual %h",
                                 $time, want.source_address, result.source_address);
                        errors++;
                    end
                    if (result.payload_length !== want.payload_length)
                    begin
                        $display("%0t: payload_length expected %0d actual %0d",
                                 $time, want.payload_length, result.payload_length);
                        errors++;
                    end
                end
            end
            // Pick up a hold-off asked by a test, counted here in cycles
            if (holds_served != holds_asked)
            begin
                hold_left = LONG_HOLD;
                holds_served++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 16) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Packets that end inside the header, and the smallest full one
    task automatic test_short_packets();
        configure(32'h0A00_0001, 8'd6);
        send_junk(1);
        send_junk(19);
        send_packet(own_addr_reg, proto_reg, 1'b1, 0);
    endtask

    // Every verdict but too-short, the verdict priority and both edges of multicast
    task automatic test_verdicts();
        configure(32'hC0A8_0102, 8'd17);
        send_packet(own_addr_reg, 8'd17, 1'b1, 1);
        send_packet(own_addr_reg, 8'd17, 1'b0, 0);
        send_packet(32'h0A0A_0A0A, 8'd17, 1'b1, 0);
        send_packet(own_addr_reg, 8'd6, 1'b1, 0);
        // Bad checksum outranks wrong destination and wrong protocol
        send_packet(32'h0A0A_0A0A, 8'd6, 1'b0, 0);
        // Wrong destination outranks wrong protocol
        send_packet(32'h0A0A_0A0A, 8'd6, 1'b1, 0);
        send_packet(32'hE000_0001, 8'd17, 1'b1, 0);
        send_packet(32'hEFFF_FFFF, 8'd17, 1'b1, 0);
        send_packet(32'hDFFF_FFFF, 8'd17, 1'b1, 0);
        send_packet(32'hF000_0000, 8'd17, 1'b1, 0);
    endtask

    // Both registers at their lowest and highest values
    task automatic test_register_extremes();
        configure(32'h0000_0000, 8'h00);
        send_packet(32'h0000_0000, 8'h00, 1'b1, 2);
        send_packet(32'h0000_0000, 8'hFF, 1'b1, 0);
        configure(32'hFFFF_FFFF, 8'hFF);
        send_packet(32'hFFFF_FFFF, 8'hFF, 1'b1, 3);
        send_packet(32'hFFFF_FFFE, 8'hFF, 1'b1, 0);
        send_packet(32'hFFFF_FFFF, 8'h00, 1'b1, 0);
    endtask

    // Byte count runs into its ceiling; payload length pins at 2027
    task automatic test_long_packet();
        configure($urandom, 8'($urandom));
        send_packet(own_addr_reg, proto_reg, 1'b1, COUNT_TOP - HDR_BYTES + 2);
        send_packet(pick_dest(), pick_proto(), 1'b1, 5);
    endtask

    // Hold the result side off while short packets keep coming, so that
    // the record queue fills and full stalls the byte input
    task automatic test_backpressure();
        configure(32'h0A00_0002, 8'd1);
        holds_asked++;
        repeat (16)
        begin
            if ($urandom_range(0, 3) == 0)
                send_packet(pick_dest(), pick_proto(), 1'b1, $urandom_range(0, 4));
            else
                send_junk($urandom_range(1, 3));
        end
    endtask

    // One random packet: mostly well formed, the rest noise and cut-offs
    task automatic send_random_packet();
        int k;
        k = $urandom_range(0, 19);
        if (k < 14)
            send_packet(pick_dest(), pick_proto(), $urandom_range(0, 6) != 0,
                        ($urandom_range(0, 4) == 0) ? $urandom_range(25, 80)
                                                    : $urandom_range(0, 24));
        else if (k < 17)
            send_junk($urandom_range(1, 19));
        else
            send_junk($urandom_range(20, 48));
    endtask

    // Random traffic in phases, each with its own register setting
    task automatic test_random_traffic();
        int target;
        int phase;
        target = bytes_fed + RANDOM_BYTES;
        phase = 0;
        while (bytes_fed < target)
        begin
            if (phase == 0)
                configure(32'h0000_0000, 8'h00);
            else if (phase == 1)
                configure(32'hFFFF_FFFF, 8'hFF);
            else if (phase == 2)
                configure({4'hE, 28'($urandom)}, 8'($urandom));
            else
                configure($urandom, 8'($urandom));
            repeat (3)
                send_random_packet();
            phase++;
        end
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_steady_flow();
        configure($urandom, 8'($urandom));
        idle_on = 1'b0;
        repeat (5)
            send_random_packet();
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        item      = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        idle_on   = 1'b1;
        errors    = 0;
        bytes_fed = 0;
        own_addr_reg = '0;
        proto_reg    = '0;
        clear_packet();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_packets();
        test_verdicts();
        test_register_extremes();
        test_long_packet();
        test_backpressure();
        test_random_traffic();
        test_steady_flow();

        settle();
        if (errors == 0 && pending_verdicts.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
